// ----- sv/fyse_pkg.sv -----
// Shared types and constants of the Fisher-Yates shuffle engine.
`default_nettype none

package fyse_pkg;

  // Width of the random word and of the serial divider.
  localparam int DIV_BITS = 32;
  localparam int CNT_W    = $clog2(DIV_BITS);

  // Stream word layouts.
  localparam int IN_DATA_W    = 48;
  localparam int IN_USER_W    = 2;
  localparam int IN_BYTE_LSB  = 0;
  localparam int IN_WORD_LSB  = 8;
  localparam int IN_RIDX_LSB  = 40;
  localparam int OUT_DATA_W   = 24;
  localparam int OUT_USER_W   = 3;
  localparam int OUT_RDAT_LSB = 0;
  localparam int OUT_PART_LSB = 8;
  localparam int OUT_DONE_BIT = 16;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RAND = 2'd1,
    OP_READ = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_SWAPPED = 3'd1,
    ST_REJECT  = 3'd2,
    ST_READ    = 3'd3,
    ST_ERROR   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_LOAD = 2'd0,
    PH_SHUF = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_N,
    S_CHECK,
    S_DIV_D,
    S_RD_P,
    S_RD_J,
    S_WR_J,
    S_WR_P,
    S_RD_WAIT,
    S_FINISH
  } fsm_t;

endpackage

`default_nettype wire

// ----- sv/fisher_yates_shuffle_engine_core.sv -----
// Top level of the Fisher-Yates shuffle engine with rejection sampling.
//
//  channel | direction | handshake         | payload
//  in_     | sink      | tvalid/tready     | tuser opcode, tlast last element, tdata 48 bits
//  out_    | source    | tvalid/tready     | tuser status, tdata 24 bits
//
// A load or a refused word goes from acceptance straight to the result state, a read through a wait state.
// A rejected random word runs the bit-serial divider only for 0xFFFFFFFF / n; one that leads
// to a swap runs it again for word / (limit / n), and the swap then passes S_RD_P, S_RD_J,
// S_WR_J and S_WR_P through the one read port.
// Reset (rst_n low, synchronous) empties the buffer; the element store is not cleared.
// A new word is taken while a result waits; a second result that cannot leave holds it.
`default_nettype none

module fisher_yates_shuffle_engine_core
  import fyse_pkg::*;
#(
  parameter int MAX_LEN    = 256,
  parameter int ELEM_WIDTH = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // byte_value [7:0], random_word [39:8], read_index [47:40]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // opcode [1:0]
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // read_data [7:0], swap_partner [15:8], shuffle_done [16], zero [23:17]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status [2:0]
  output logic [OUT_USER_W-1:0]      out_tuser
);

  localparam int PW = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = (LW > 8) ? LW : 8;

  // Element store and its ports.
  logic [ELEM_WIDTH-1:0] elem_store_r [MAX_LEN];
  logic [ELEM_WIDTH-1:0] mem_rd_r;
  logic                  mem_we;
  logic [PW-1:0]         mem_wa;
  logic [PW-1:0]         mem_ra;
  logic [ELEM_WIDTH-1:0] mem_wd;

  fsm_t                  state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [PW-1:0]         j_r, j_nxt;
  logic [ELEM_WIDTH-1:0] hold_r, hold_nxt;
  logic [DIV_BITS-1:0]   word_r, word_nxt;
  logic [DIV_BITS-1:0]   quo_r, quo_nxt;
  logic [DIV_BITS-1:0]   rem_r, rem_nxt;
  logic [DIV_BITS-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [7:0]            res_rdata_r, res_rdata_nxt;
  logic [7:0]            res_part_r, res_part_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  status_t               out_status_r, out_status_nxt;

  logic [7:0]            in_byte;
  logic [7:0]            in_ridx;
  opcode_t               in_op;
  logic [LW-1:0]         eff_len;
  logic [LW-1:0]         new_len;
  logic [DIV_BITS-1:0]   rem_sh;
  logic                  sub_ok;

  assign in_byte = in_tdata[IN_BYTE_LSB +: 8];
  assign in_ridx = in_tdata[IN_RIDX_LSB +: 8];
  assign in_op   = opcode_t'(in_tuser);

  // One restoring division step: the next dividend bit enters the partial remainder.
  assign rem_sh = {rem_r[DIV_BITS-2:0], quo_r[DIV_BITS-1]};
  assign sub_ok = (rem_sh >= dvs_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_store_r[mem_wa] <= mem_wd;
    end
    mem_rd_r <= elem_store_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LOAD;
      len_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r          <= j_nxt;
    hold_r       <= hold_nxt;
    word_r       <= word_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    dvs_r        <= dvs_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_rdata_r  <= res_rdata_nxt;
    res_part_r   <= res_part_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    j_nxt          = j_r;
    hold_nxt       = hold_r;
    word_nxt       = word_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_rdata_nxt  = res_rdata_r;
    res_part_nxt   = res_part_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = pos_r;
    mem_wd         = hold_r;
    mem_ra         = PW'(in_ridx);
    eff_len        = (phase_r == PH_DONE) ? '0 : len_r;
    new_len        = eff_len;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          word_nxt       = in_tdata[IN_WORD_LSB +: DIV_BITS];
          res_status_nxt = ST_ERROR;
          res_rdata_nxt  = '0;
          res_part_nxt   = '0;
          state_nxt      = S_FINISH;
          case (in_op)
            OP_LOAD: begin
              if (phase_r != PH_SHUF) begin
                // A load after a finished shuffle starts a fresh buffer.
                if (eff_len < LW'(MAX_LEN)) begin
                  mem_we         = 1'b1;
                  mem_wa         = PW'(eff_len);
                  mem_wd         = ELEM_WIDTH'(in_byte);
                  new_len        = eff_len + LW'(1);
                  res_status_nxt = ST_LOADED;
                end
                len_nxt   = new_len;
                phase_nxt = PH_LOAD;
                pos_nxt   = '0;
                if (in_tlast) begin
                  if (new_len <= LW'(1)) begin
                    phase_nxt = PH_DONE;
                  end else begin
                    phase_nxt = PH_SHUF;
                    pos_nxt   = PW'(new_len - LW'(1));
                  end
                end
              end
            end
            OP_RAND: begin
              if (phase_r == PH_SHUF) begin
                quo_nxt   = '1;
                rem_nxt   = '0;
                dvs_nxt   = DIV_BITS'(pos_r) + DIV_BITS'(1);
                cnt_nxt   = '0;
                state_nxt = S_DIV_N;
              end
            end
            OP_READ: begin
              if (phase_r == PH_DONE && CW'(in_ridx) < CW'(len_r)) begin
                state_nxt = S_RD_WAIT;
              end
            end
            default: begin
              res_status_nxt = ST_ERROR;
            end
          endcase
        end
      end

      S_DIV_N, S_DIV_D: begin
        rem_nxt = sub_ok ? (rem_sh - dvs_r) : rem_sh;
        quo_nxt = {quo_r[DIV_BITS-2:0], sub_ok};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '1) begin
          state_nxt = (state_r == S_DIV_N) ? S_CHECK : S_RD_P;
        end
      end

      S_CHECK: begin
        // quo_r holds 0xFFFFFFFF / n and rem_r the remainder, so ~rem_r is the limit.
        if (word_r >= ~rem_r) begin
          res_status_nxt = ST_REJECT;
          state_nxt      = S_FINISH;
        end else begin
          quo_nxt   = word_r;
          dvs_nxt   = quo_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV_D;
        end
      end

      S_RD_P: begin
        mem_ra    = pos_r;
        j_nxt     = (quo_r > DIV_BITS'(pos_r)) ? pos_r : PW'(quo_r);
        state_nxt = S_RD_J;
      end

      S_RD_J: begin
        mem_ra    = j_r;
        hold_nxt  = mem_rd_r;
        state_nxt = S_WR_J;
      end

      S_WR_J: begin
        // Element p goes to j while element j is taken into the holding register.
        mem_we    = 1'b1;
        mem_wa    = j_r;
        mem_wd    = hold_r;
        hold_nxt  = mem_rd_r;
        state_nxt = S_WR_P;
      end

      S_WR_P: begin
        mem_we         = 1'b1;
        mem_wa         = pos_r;
        mem_wd         = hold_r;
        res_status_nxt = ST_SWAPPED;
        res_part_nxt   = 8'(j_r);
        pos_nxt        = pos_r - PW'(1);
        if (pos_r == PW'(1)) begin
          phase_nxt = PH_DONE;
        end
        state_nxt = S_FINISH;
      end

      S_RD_WAIT: begin
        res_status_nxt = ST_READ;
        res_rdata_nxt  = 8'(mem_rd_r);
        state_nxt      = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = {7'd0, (phase_r == PH_DONE), res_part_r, res_rdata_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/fyse_checker.sv -----
// Port-level checker for the shuffle engine, bound to its top level.
`default_nettype none

module fyse_checker
  import fyse_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Elements can only be read back once the shuffle has finished.
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_READ |-> out_tdata[OUT_DONE_BIT])
    else $error("read data returned before the shuffle finished");

  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_READ |-> out_tdata[OUT_RDAT_LSB +: 8] == 8'd0)
    else $error("read data not zero on a non-read result");

  a_part_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_SWAPPED |-> out_tdata[OUT_PART_LSB +: 8] == 8'd0)
    else $error("swap partner not zero on a non-swap result");

endmodule

bind fisher_yates_shuffle_engine_core fyse_checker u_fyse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
